// ===== rtl/core/atp_pkg.sv =====
// ----------------------------------------------------------------------------
// atp_pkg
// Shared types and fixed constants for the polynomial atan2 pipeline.
// ----------------------------------------------------------------------------
package atp_pkg;

  // Ratio z is Q1.15; its magnitude runs up to 1.0, so it needs 16 bits
  localparam int Z_FRAC = 15;
  localparam int Q_BITS = Z_FRAC + 1;

  // Polynomial coefficients, Q1.15
  localparam logic [14:0]        COEF_N1 = 15'd31863;
  localparam logic signed [14:0] COEF_N2 = -15'sd6290;

  // q*q fits 31 bits; t = n1*2^30 + n2*q*q is positive and below 2^45
  localparam int Q2_BITS  = 2 * Z_FRAC + 1;
  localparam int T_BITS   = 45;
  localparam int T_FULL   = T_BITS + 2;
  localparam int T_LO     = 23;
  localparam int T_HI     = T_BITS - T_LO;
  localparam int PP_LO_W  = T_LO + Q_BITS;
  localparam int PP_HI_W  = T_HI + Q_BITS;
  localparam int P_BITS   = T_BITS + Q_BITS;
  localparam int ACC_BITS = 64;

  localparam logic [T_BITS-1:0] N1_Q45 = T_BITS'(COEF_N1) << (2 * Z_FRAC);

  // Angles in Q.60, rounded to nearest
  localparam logic signed [ACC_BITS-1:0] PI_Q60      = 64'sh3243F6A8885A308D;
  localparam logic signed [ACC_BITS-1:0] HALF_PI_Q60 = 64'sh1921FB54442D1847;

  // Constant the polynomial term is added to, by quadrant and octant
  typedef enum logic [2:0] {
    BASE_ZERO,
    BASE_POS_PI,
    BASE_NEG_PI,
    BASE_POS_HALF,
    BASE_NEG_HALF
  } base_sel_t;

  // Per-item side information that rides along the pipeline
  typedef struct packed {
    logic      sub;    // subtract the polynomial term instead of adding it
    base_sel_t base;
  } side_t;

endpackage

// ===== rtl/core/atp_div_cell.sv =====
// ----------------------------------------------------------------------------
// atp_div_cell
// One restoring-division cell: resolves one quotient bit per item and hands
// the partial remainder, divisor and quotient on to the next cell.
// ----------------------------------------------------------------------------
module atp_div_cell
  import atp_pkg::*;
#(
  parameter int RW = 17
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              valid_i,
  output logic              ready_o,
  input  logic [RW-1:0]     rem_i,
  input  logic [RW-1:0]     den_i,
  input  logic [Q_BITS-1:0] quo_i,
  input  side_t             side_i,
  output logic              valid_o,
  input  logic              ready_i,
  output logic [RW-1:0]     rem_o,
  output logic [RW-1:0]     den_o,
  output logic [Q_BITS-1:0] quo_o,
  output side_t             side_o
);

  logic              valid_r;
  logic [RW-1:0]     rem_r, rem_nxt;
  logic [RW-1:0]     den_r;
  logic [Q_BITS-1:0] quo_r, quo_nxt;
  side_t             side_r;
  logic [RW:0]       trial;
  logic [RW:0]       diff;
  logic              ge;

  // Shift, trial subtract, restore
  always_comb begin
    trial   = {rem_i, 1'b0};
    diff    = trial - {1'b0, den_i};
    ge      = (trial >= {1'b0, den_i});
    rem_nxt = ge ? diff[RW-1:0] : trial[RW-1:0];
    quo_nxt = {quo_i[Q_BITS-2:0], ge};
  end

  // Cell holds its item until the next cell takes it
  assign ready_o = !valid_r || ready_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      rem_r  <= rem_nxt;
      den_r  <= den_i;
      quo_r  <= quo_nxt;
      side_r <= side_i;
    end
  end

  assign valid_o = valid_r;
  assign rem_o   = rem_r;
  assign den_o   = den_r;
  assign quo_o   = quo_r;
  assign side_o  = side_r;

endmodule

// ===== rtl/core/atp_poly.sv =====
// ----------------------------------------------------------------------------
// atp_poly
// Four-stage evaluation of (n1 + n2*q*q)*q on the ratio magnitude, exact
// in Q.60.
// ----------------------------------------------------------------------------
module atp_poly
  import atp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              valid_i,
  output logic              ready_o,
  input  logic [Q_BITS-1:0] q_i,
  input  side_t             side_i,
  output logic              valid_o,
  input  logic              ready_i,
  output logic [P_BITS-1:0] p_o,
  output side_t             side_o
);

  localparam int NSTG = 4;

  logic [NSTG-1:0]          v_r;
  logic [NSTG-1:0]          rdy;
  side_t                    side_r [NSTG];

  logic [Q_BITS-1:0]        q1_r, q2_r;
  logic [Q2_BITS-1:0]       qsq_r;
  logic [2*Q_BITS-1:0]      qsq_full;
  logic [T_BITS-1:0]        t_r;
  logic signed [T_FULL-1:0] n2_term;
  logic signed [T_FULL-1:0] t_full;
  logic [PP_LO_W-1:0]       pp_lo_r;
  logic [PP_HI_W-1:0]       pp_hi_r;
  logic [P_BITS-1:0]        p_r;

  // Ready chain: a stage loads when empty or when its item moves on
  always_comb begin
    rdy[NSTG-1] = !v_r[NSTG-1] || ready_i;
    for (int i = NSTG - 2; i >= 0; i--) begin
      rdy[i] = !v_r[i] || rdy[i+1];
    end
  end

  assign ready_o = rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) v_r[0] <= valid_i;
      for (int i = 1; i < NSTG; i++) begin
        if (rdy[i]) v_r[i] <= v_r[i-1];
      end
    end
  end

  // Stage 0: square of the ratio
  assign qsq_full = q_i * q_i;

  always_ff @(posedge clk) begin
    if (rdy[0] && valid_i) begin
      q1_r      <= q_i;
      qsq_r     <= qsq_full[Q2_BITS-1:0];
      side_r[0] <= side_i;
    end
  end

  // Stage 1: t = n1*2^30 + n2*q*q
  always_comb begin
    n2_term = COEF_N2 * $signed({1'b0, qsq_r});
    t_full  = $signed({2'b00, N1_Q45}) + n2_term;
  end

  always_ff @(posedge clk) begin
    if (rdy[1] && v_r[0]) begin
      q2_r      <= q1_r;
      t_r       <= t_full[T_BITS-1:0];
      side_r[1] <= side_r[0];
    end
  end

  // Stage 2: t*q as two partial products
  always_ff @(posedge clk) begin
    if (rdy[2] && v_r[1]) begin
      pp_lo_r   <= PP_LO_W'(t_r[T_LO-1:0]) * PP_LO_W'(q2_r);
      pp_hi_r   <= PP_HI_W'(t_r[T_BITS-1:T_LO]) * PP_HI_W'(q2_r);
      side_r[2] <= side_r[1];
    end
  end

  // Stage 3: combine partial products
  always_ff @(posedge clk) begin
    if (rdy[3] && v_r[2]) begin
      p_r       <= (P_BITS'(pp_hi_r) << T_LO) + P_BITS'(pp_lo_r);
      side_r[3] <= side_r[2];
    end
  end

  assign valid_o = v_r[NSTG-1];
  assign p_o     = p_r;
  assign side_o  = side_r[NSTG-1];

endmodule

// ===== rtl/core/atan2_polynomial_approx.sv =====
// ----------------------------------------------------------------------------
// atan2_polynomial_approx
// Four-quadrant arctangent by third-order polynomial on min/max ratio.
// ----------------------------------------------------------------------------
//  channel | ports                                   | dir | item
//  --------+-----------------------------------------+-----+-----------------
//  input   | in_valid, in_stall, in_x/y_component    | in  | x, y components
//  result  | out_valid, out_stall, out_angle         | out | angle, Q3.F rad
//
//  One item per cycle sustained while out_stall is low. The path is one front
//  stage, one divider cell per quotient bit (16), four polynomial stages, one
//  correction stage and the output register.
//  Every stage holds its own item, so bubbles close up when out_stall is high
//  and in_stall rises only once the whole pipeline is full.
//  rst_n is synchronous and clears only the stage valid flags.
// ----------------------------------------------------------------------------
module atan2_polynomial_approx
  import atp_pkg::*;
#(
  parameter int IN_BITS       = 16,
  parameter int OUT_FRAC_BITS = 13
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [IN_BITS-1:0]       in_x_component,
  input  logic signed [IN_BITS-1:0]       in_y_component,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [OUT_FRAC_BITS+2:0] out_angle
);

  localparam int RW   = IN_BITS + 1;
  localparam int OW   = OUT_FRAC_BITS + 3;
  localparam int DROP = 60 - OUT_FRAC_BITS;

  localparam logic signed [ACC_BITS-1:0] HALF_LSB  = 64'sd1 <<< (DROP - 1);
  localparam logic signed [ACC_BITS-1:0] LIM       = (PI_Q60 + HALF_LSB) >>> DROP;
  localparam logic signed [ACC_BITS-1:0] NEG_LIM   = -LIM;
  localparam logic signed [ACC_BITS-1:0] RND_ZERO  = HALF_LSB;
  localparam logic signed [ACC_BITS-1:0] RND_PPI   = PI_Q60 + HALF_LSB;
  localparam logic signed [ACC_BITS-1:0] RND_NPI   = HALF_LSB - PI_Q60;
  localparam logic signed [ACC_BITS-1:0] RND_PHALF = HALF_PI_Q60 + HALF_LSB;
  localparam logic signed [ACC_BITS-1:0] RND_NHALF = HALF_LSB - HALF_PI_Q60;

  // --------------------------------------------------------------------------
  // Front stage: magnitudes, octant decode, divider operands
  // --------------------------------------------------------------------------
  logic               x_neg, y_neg, x_dom;
  logic [IN_BITS-1:0] mag_x, mag_y, num, den;
  side_t              side_f;

  logic               vf_r;
  logic               rdy_f;
  logic [RW-1:0]      num_r, den2_r;
  side_t              side_f_r;

  always_comb begin
    x_neg = in_x_component[IN_BITS-1];
    y_neg = in_y_component[IN_BITS-1];
    mag_x = x_neg ? (~in_x_component + 1'b1) : in_x_component;
    mag_y = y_neg ? (~in_y_component + 1'b1) : in_y_component;
    x_dom = (mag_x > mag_y);
    num   = x_dom ? mag_y : mag_x;
    den   = x_dom ? mag_x : mag_y;
    // both zero: force 0/1 so the ratio and the term come out zero
    if (den == '0) begin
      den = IN_BITS'(1);
    end
    side_f.sub = x_neg ^ y_neg ^ !x_dom;
    if (x_dom) begin
      if (!x_neg) begin
        side_f.base = BASE_ZERO;
      end else if (y_neg) begin
        side_f.base = BASE_NEG_PI;
      end else begin
        side_f.base = BASE_POS_PI;
      end
    end else if (y_neg) begin
      side_f.base = BASE_NEG_HALF;
    end else if (mag_y != '0) begin
      side_f.base = BASE_POS_HALF;
    end else begin
      side_f.base = BASE_ZERO;
    end
  end

  logic [Q_BITS:0]   dv;
  logic [Q_BITS:0]   drdy;
  logic [RW-1:0]     drem [Q_BITS+1];
  logic [RW-1:0]     dden [Q_BITS+1];
  logic [Q_BITS-1:0] dquo [Q_BITS+1];
  side_t             dside [Q_BITS+1];

  assign rdy_f    = !vf_r || drdy[0];
  assign in_stall = !rdy_f;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vf_r <= 1'b0;
    end else if (rdy_f) begin
      vf_r <= in_valid;
    end
  end

  // Divisor is doubled so every cell does the same shift and compare
  always_ff @(posedge clk) begin
    if (rdy_f && in_valid) begin
      num_r    <= {1'b0, num};
      den2_r   <= {den, 1'b0};
      side_f_r <= side_f;
    end
  end

  // --------------------------------------------------------------------------
  // Divider: row of cells, one quotient bit each, MSB first
  // --------------------------------------------------------------------------
  assign dv[0]    = vf_r;
  assign drem[0]  = num_r;
  assign dden[0]  = den2_r;
  assign dquo[0]  = '0;
  assign dside[0] = side_f_r;

  for (genvar g = 0; g < Q_BITS; g++) begin : g_div
    atp_div_cell #(
      .RW (RW)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .valid_i (dv[g]),
      .ready_o (drdy[g]),
      .rem_i   (drem[g]),
      .den_i   (dden[g]),
      .quo_i   (dquo[g]),
      .side_i  (dside[g]),
      .valid_o (dv[g+1]),
      .ready_i (drdy[g+1]),
      .rem_o   (drem[g+1]),
      .den_o   (dden[g+1]),
      .quo_o   (dquo[g+1]),
      .side_o  (dside[g+1])
    );
  end

  // --------------------------------------------------------------------------
  // Polynomial
  // --------------------------------------------------------------------------
  logic              pv;
  logic              rdy_a;
  logic [P_BITS-1:0] p;
  side_t             pside;

  atp_poly u_poly (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (dv[Q_BITS]),
    .ready_o (drdy[Q_BITS]),
    .q_i     (dquo[Q_BITS]),
    .side_i  (dside[Q_BITS]),
    .valid_o (pv),
    .ready_i (rdy_a),
    .p_o     (p),
    .side_o  (pside)
  );

  // --------------------------------------------------------------------------
  // Correction: base angle (with rounding half folded in) plus or minus term
  // --------------------------------------------------------------------------
  logic                       va_r, vb_r, rdy_b;
  logic signed [ACC_BITS-1:0] base_c, pe, a_nxt, a_r;
  logic signed [ACC_BITS-1:0] r_sh;
  logic signed [ACC_BITS-1:0] r_sat;
  logic [OW-1:0]              angle_r;

  always_comb begin
    case (pside.base)
      BASE_ZERO:     base_c = RND_ZERO;
      BASE_POS_PI:   base_c = RND_PPI;
      BASE_NEG_PI:   base_c = RND_NPI;
      BASE_POS_HALF: base_c = RND_PHALF;
      BASE_NEG_HALF: base_c = RND_NHALF;
      default:       base_c = RND_ZERO;
    endcase
    pe    = $signed(ACC_BITS'(p));
    a_nxt = pside.sub ? (base_c - pe) : (base_c + pe);
  end

  assign rdy_b = !vb_r || !out_stall;
  assign rdy_a = !va_r || rdy_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      if (rdy_a) va_r <= pv;
      if (rdy_b) vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a && pv) begin
      a_r <= a_nxt;
    end
  end

  // Floor to output precision, then clamp to +-pi
  always_comb begin
    r_sh = a_r >>> DROP;
    if (r_sh > LIM) begin
      r_sat = LIM;
    end else if (r_sh < NEG_LIM) begin
      r_sat = NEG_LIM;
    end else begin
      r_sat = r_sh;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_b && va_r) begin
      angle_r <= r_sat[OW-1:0];
    end
  end

  assign out_valid = vb_r;
  assign out_angle = $signed(angle_r);

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // Result never leaves the +-pi band
  a_angle_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((ACC_BITS'(out_angle) <= LIM) && (ACC_BITS'(out_angle) >= NEG_LIM)))
    else $error("angle outside +-pi");

  // Ratio never exceeds 1.0: a set top bit means exactly 1.0
  a_ratio_le_one : assert property (@(posedge clk) disable iff (!rst_n)
    (dv[Q_BITS] && dquo[Q_BITS][Q_BITS-1]) |-> (dquo[Q_BITS][Q_BITS-2:0] == '0))
    else $error("divider ratio above one");

  // An accepted item always lands in the front stage
  a_accept_lands : assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> vf_r)
    else $error("accepted item lost at front stage");

  // Stalled output keeps the correction stage from overrunning it
  a_hold_output : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall && va_r) |=> (va_r && $stable(a_r)))
    else $error("correction stage advanced into stalled output");

endmodule
